### src/linear_regression_fit_score_assert.svh
// Assertion macros shared by the regression block
`ifndef LINEAR_REGRESSION_FIT_SCORE_ASSERT_SVH
`define LINEAR_REGRESSION_FIT_SCORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LRFS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LRFS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lrfs_pkg.sv
package lrfs_pkg;

  // Sample limits and fixed-point format
  localparam int MAX_SAMPLES = 65536;
  localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int FRAC_BITS   = 16;
  localparam int CORR_BITS   = 30;

  // Accumulator and datapath widths
  localparam int SUM_W  = 48;
  localparam int ACC_W  = 64;
  localparam int WIDE_W = 68;
  localparam int MUL_W  = 34;
  localparam int DVD_W  = ACC_W + CORR_BITS;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int ROOT_STEPS = ACC_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam logic [DVD_W-1:0] DIV_CAP = DVD_W'(1) << 40;
  localparam logic signed [ACC_W-1:0] CORR_MAX = ACC_W'(1) << CORR_BITS;
  localparam logic signed [31:0] CORR_MAX32 = 32'(1) << CORR_BITS;
  localparam logic signed [WIDE_W-1:0] ONE_FX = WIDE_W'(1) << FRAC_BITS;

  // Request / result kinds
  localparam logic [1:0] REQ_FIT     = 2'd0;
  localparam logic [1:0] REQ_SCORE   = 2'd1;
  localparam logic [1:0] REQ_PREDICT = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // Divider scaling modes
  typedef enum logic [1:0] {
    DIV_INT  = 2'd0,
    DIV_FRAC = 2'd1,
    DIV_CORR = 2'd2
  } div_mode_t;

  typedef struct packed {
    logic      start;
    div_mode_t mode;
  } div_ctrl_t;

  // Saturate a wide signed value to 32, 48 or 64 bits
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:31] == '0 || v[WIDE_W-1:31] == '1) sat32 = v[31:0];
    else sat32 = v[WIDE_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:SUM_W-1] == '0 || v[WIDE_W-1:SUM_W-1] == '1) sat48 = v[SUM_W-1:0];
    else sat48 = v[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:ACC_W-1] == '0 || v[WIDE_W-1:ACC_W-1] == '1) sat64 = v[ACC_W-1:0];
    else sat64 = v[WIDE_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

endpackage

### src/lrfs_div.sv
module lrfs_div import lrfs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  div_ctrl_t               ctrl,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output logic                    done,
  output logic signed [ACC_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     dvd;
  logic [DVD_W-1:0]     quo;
  logic [ACC_W:0]       rem;
  logic [ACC_W-1:0]     dsr;
  logic                 neg;
  logic                 cap;

  logic [ACC_W-1:0]     num_mag;
  logic [ACC_W-1:0]     den_mag;
  logic [ACC_W:0]       rem_sh;
  logic [ACC_W+1:0]     diff;
  logic                 fits;
  logic [DVD_W-1:0]     quo_next;
  logic [ACC_W-1:0]     mag;

  // Magnitudes and one restoring step
  always_comb begin
    num_mag  = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
    den_mag  = den[ACC_W-1] ? (~den + ACC_W'(1)) : den;
    rem_sh   = {rem[ACC_W-1:0], dvd[DVD_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr};
    fits     = !diff[ACC_W+1];
    quo_next = {quo[DVD_W-2:0], fits};
    if (cap && quo_next > DIV_CAP) mag = DIV_CAP[ACC_W-1:0];
    else mag = quo_next[ACC_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift/subtract datapath, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      unique case (ctrl.mode)
        DIV_INT:  dvd <= DVD_W'(num_mag);
        DIV_FRAC: dvd <= DVD_W'(num_mag) << FRAC_BITS;
        DIV_CORR: dvd <= DVD_W'(num_mag) << CORR_BITS;
        default:  dvd <= DVD_W'(num_mag);
      endcase
      dsr <= den_mag;
      rem <= '0;
      quo <= '0;
      neg <= num[ACC_W-1] ^ den[ACC_W-1];
      cap <= (ctrl.mode != DIV_INT);
      cnt <= DIV_CNT_W'(DVD_W - 1);
    end else if (busy) begin
      rem <= fits ? diff[ACC_W:0] : rem_sh;
      quo <= quo_next;
      dvd <= dvd << 1;
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == '0) quot <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

### src/lrfs_sqrt.sv
module lrfs_sqrt import lrfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] value,
  output logic             done,
  output logic [31:0]      root
);

  logic                  busy;
  logic [ROOT_CNT_W-1:0] cnt;
  logic [ACC_W-1:0]      val;
  logic [ACC_W-1:0]      res;
  logic [ACC_W-1:0]      probe;
  logic [ACC_W-1:0]      trial;
  logic                  ge;
  logic [ACC_W-1:0]      res_next;

  // One digit of the root per cycle
  always_comb begin
    trial    = res + probe;
    ge       = val >= trial;
    res_next = ge ? ((res >> 1) + probe) : (res >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val   <= value;
      res   <= '0;
      probe <= ACC_W'(1) << (ACC_W - 2);
      cnt   <= ROOT_CNT_W'(ROOT_STEPS - 1);
    end else if (busy) begin
      if (ge) val <= val - trial;
      res   <= res_next;
      probe <= probe >> 2;
      cnt   <= cnt - ROOT_CNT_W'(1);
      if (cnt == '0) root <= res_next[31:0];
    end
  end

endmodule

### src/linear_regression_fit_score.sv
// Least-squares line fit, scoring and prediction on signed Q16.16 samples.
// Input channel s_*: one request per transfer; s_tuser gives the kind
// (fit sample, score sample, predict), s_tlast closes a fit or score set.
// Output channel m_*: one result per closing fit/score request and per
// prediction; other requests give no result.
// Work per request, accept to result register:
//   fit or score sample, not last: accumulate the sums, then idle
//   predict: one product, then the result
//   closing fit: up to seven divisions and two roots;
//   closing score: up to four divisions.
// The bit-serial divider (94 quotient bits, one per cycle) does the long part;
// all products go through one registered 34x34 multiplier.
// s_tready is high only while the sequencer is idle.
// Reset clears the sums, counts and the model (slope and intercept zero).
// A single output register holds the result; the next request is accepted
// while it waits, and a new result waits in the sequencer until m_tready.
`include "linear_regression_fit_score_assert.svh"

module linear_regression_fit_score import lrfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // x_value[31:0], y_value[63:32]
  input  logic [1:0]   s_tuser,   // req_type[1:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slope[31:0], intercept[63:32], correlation[95:64], r_squared[127:96],
  // prediction[159:128]
  output logic [159:0] m_tdata,
  output logic [2:0]   m_tuser    // result_kind[1:0], degenerate[2]
);

  typedef enum logic [33:0] {
    ST_IDLE     = 34'd1 << 0,
    ST_F_XX     = 34'd1 << 1,
    ST_F_YY     = 34'd1 << 2,
    ST_F_XY     = 34'd1 << 3,
    ST_F_XYA    = 34'd1 << 4,
    ST_FD_SX    = 34'd1 << 5,
    ST_FD_SY    = 34'd1 << 6,
    ST_FD_SXX   = 34'd1 << 7,
    ST_FM_VX    = 34'd1 << 8,
    ST_FA_VX    = 34'd1 << 9,
    ST_FD_SYY   = 34'd1 << 10,
    ST_FM_VY    = 34'd1 << 11,
    ST_FA_VY    = 34'd1 << 12,
    ST_FD_SXY   = 34'd1 << 13,
    ST_FM_COV   = 34'd1 << 14,
    ST_FA_COV   = 34'd1 << 15,
    ST_FD_SLOPE = 34'd1 << 16,
    ST_FM_ICPT  = 34'd1 << 17,
    ST_FA_ICPT  = 34'd1 << 18,
    ST_FQ_X     = 34'd1 << 19,
    ST_FQ_Y     = 34'd1 << 20,
    ST_FM_DEN   = 34'd1 << 21,
    ST_FD_CORR  = 34'd1 << 22,
    ST_S_P      = 34'd1 << 23,
    ST_S_PA     = 34'd1 << 24,
    ST_S_EE     = 34'd1 << 25,
    ST_S_EEA    = 34'd1 << 26,
    ST_SD_SY    = 34'd1 << 27,
    ST_SD_SYY   = 34'd1 << 28,
    ST_SM_SST   = 34'd1 << 29,
    ST_SA_SST   = 34'd1 << 30,
    ST_SD_SSR   = 34'd1 << 31,
    ST_SD_R2    = 34'd1 << 32,
    ST_DONE     = 34'd1 << 33
  } state_t;

  state_t state;
  logic   issued;

  // Accumulators and model
  logic [COUNT_W-1:0]      fit_count;
  logic signed [SUM_W-1:0] fit_sum_x;
  logic signed [SUM_W-1:0] fit_sum_y;
  logic signed [ACC_W-1:0] fit_sum_xx;
  logic signed [ACC_W-1:0] fit_sum_yy;
  logic signed [ACC_W-1:0] fit_sum_xy;
  logic signed [31:0]      model_slope;
  logic signed [31:0]      model_intercept;
  logic [COUNT_W-1:0]      score_count;
  logic signed [SUM_W-1:0] score_sum_y;
  logic signed [ACC_W-1:0] score_sum_yy;
  logic signed [ACC_W-1:0] residual_sq_sum;

  // Request and working registers
  logic signed [31:0]      x_r;
  logic signed [31:0]      y_r;
  logic [1:0]              kind_r;
  logic                    last_r;
  logic signed [31:0]      mx;
  logic signed [31:0]      my;
  logic signed [ACC_W-1:0] vx;
  logic signed [ACC_W-1:0] vy;
  logic signed [ACC_W-1:0] cov;
  logic signed [31:0]      slope_r;
  logic [31:0]             e_r;
  logic [31:0]             sx;
  logic signed [31:0]      corr_r;
  logic signed [31:0]      r2_r;
  logic signed [31:0]      pred_r;
  logic                    deg_r;

  // Shared multiplier
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [WIDE_W-1:0] prod;

  // Divider and root units
  div_ctrl_t               div_ctrl;
  logic signed [ACC_W-1:0] div_num;
  logic signed [ACC_W-1:0] div_den;
  logic                    div_done;
  logic signed [ACC_W-1:0] div_quot;
  logic                    sq_start;
  logic [ACC_W-1:0]        sq_value;
  logic                    sq_done;
  logic [31:0]             sq_root;

  // Derived values
  logic signed [WIDE_W-1:0] prod_fl;
  logic signed [WIDE_W-1:0] q_w;
  logic signed [WIDE_W-1:0] var_raw;
  logic signed [ACC_W-1:0]  var_v;
  logic signed [31:0]       pred_v;
  logic signed [32:0]       e_diff;
  logic signed [32:0]       e_neg;
  logic signed [31:0]       corr_v;
  logic                     fit_full;
  logic                     score_full;
  logic signed [ACC_W-1:0]  n_fit;
  logic signed [ACC_W-1:0]  n_score;

  always_comb begin
    prod_fl    = prod >>> FRAC_BITS;
    q_w        = WIDE_W'(div_quot);
    var_raw    = q_w - prod_fl;
    var_v      = var_raw[WIDE_W-1] ? '0 : var_raw[ACC_W-1:0];
    pred_v     = sat32(prod_fl + WIDE_W'(model_intercept));
    e_diff     = 33'(pred_v) - 33'(y_r);
    e_neg      = -e_diff;
    fit_full   = fit_count == COUNT_W'(MAX_SAMPLES);
    score_full = score_count == COUNT_W'(MAX_SAMPLES);
    n_fit      = $signed(ACC_W'(fit_count));
    n_score    = $signed(ACC_W'(score_count));
    if (div_quot > CORR_MAX) corr_v = CORR_MAX32;
    else if (div_quot < -CORR_MAX) corr_v = -CORR_MAX32;
    else corr_v = div_quot[31:0];
  end

  // Multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = MUL_W'(x_r);
    mul_b  = MUL_W'(x_r);
    unique case (state)
      ST_F_XX:    begin mul_a = MUL_W'(x_r); mul_b = MUL_W'(x_r); end
      ST_F_YY:    begin mul_a = MUL_W'(y_r); mul_b = MUL_W'(y_r); end
      ST_F_XY:    begin mul_a = MUL_W'(x_r); mul_b = MUL_W'(y_r); end
      ST_FM_VX:   begin mul_a = MUL_W'(mx); mul_b = MUL_W'(mx); end
      ST_FM_VY:   begin mul_a = MUL_W'(my); mul_b = MUL_W'(my); end
      ST_FM_COV:  begin mul_a = MUL_W'(mx); mul_b = MUL_W'(my); end
      ST_FM_ICPT: begin mul_a = MUL_W'(slope_r); mul_b = MUL_W'(mx); end
      ST_FM_DEN:  begin mul_a = $signed({2'b00, sx}); mul_b = $signed({2'b00, sq_root}); end
      ST_S_P:     begin mul_a = MUL_W'(model_slope); mul_b = MUL_W'(x_r); end
      ST_S_PA:    begin mul_a = MUL_W'(y_r); mul_b = MUL_W'(y_r); end
      ST_S_EE:    begin mul_a = $signed({2'b00, e_r}); mul_b = $signed({2'b00, e_r}); end
      ST_SM_SST:  begin mul_a = MUL_W'(my); mul_b = MUL_W'(my); end
      default:    mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
  end

  // Divider operand selection
  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.mode  = DIV_INT;
    div_num        = ACC_W'(fit_sum_x);
    div_den        = n_fit;
    unique case (state)
      ST_FD_SX:    begin div_ctrl.start = !issued; div_num = ACC_W'(fit_sum_x); end
      ST_FD_SY:    begin div_ctrl.start = !issued; div_num = ACC_W'(fit_sum_y); end
      ST_FD_SXX:   begin div_ctrl.start = !issued; div_num = fit_sum_xx; end
      ST_FD_SYY:   begin div_ctrl.start = !issued; div_num = fit_sum_yy; end
      ST_FD_SXY:   begin div_ctrl.start = !issued; div_num = fit_sum_xy; end
      ST_FD_SLOPE: begin
        div_ctrl.start = !issued;
        div_ctrl.mode  = DIV_FRAC;
        div_num        = cov;
        div_den        = vx;
      end
      ST_FD_CORR: begin
        div_ctrl.start = !issued;
        div_ctrl.mode  = DIV_CORR;
        div_num        = cov;
        div_den        = prod[ACC_W-1:0];
      end
      ST_SD_SY: begin
        div_ctrl.start = !issued;
        div_num        = ACC_W'(score_sum_y);
        div_den        = n_score;
      end
      ST_SD_SYY: begin
        div_ctrl.start = !issued;
        div_num        = score_sum_yy;
        div_den        = n_score;
      end
      ST_SD_SSR: begin
        div_ctrl.start = !issued;
        div_num        = residual_sq_sum;
        div_den        = n_score;
      end
      ST_SD_R2: begin
        div_ctrl.start = !issued;
        div_ctrl.mode  = DIV_FRAC;
        div_num        = cov;
        div_den        = vx;
      end
      default: ;
    endcase
  end

  // Root unit operand
  always_comb begin
    sq_start = 1'b0;
    sq_value = vx;
    unique case (state)
      ST_FQ_X: begin sq_start = !issued; sq_value = vx; end
      ST_FQ_Y: begin sq_start = !issued; sq_value = vy; end
      default: ;
    endcase
  end

  lrfs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  lrfs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign s_tready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      issued          <= 1'b0;
      m_tvalid        <= 1'b0;
      fit_count       <= '0;
      fit_sum_x       <= '0;
      fit_sum_y       <= '0;
      fit_sum_xx      <= '0;
      fit_sum_yy      <= '0;
      fit_sum_xy      <= '0;
      model_slope     <= '0;
      model_intercept <= '0;
      score_count     <= '0;
      score_sum_y     <= '0;
      score_sum_yy    <= '0;
      residual_sq_sum <= '0;
    end else begin
      // ST_DONE reloads the output register itself
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      if (div_ctrl.start || sq_start) issued <= 1'b1;

      unique case (state)
        // Take a request
        ST_IDLE: begin
          if (s_tvalid) begin
            x_r    <= s_tdata[31:0];
            y_r    <= s_tdata[63:32];
            kind_r <= s_tuser;
            last_r <= s_tlast;
            corr_r <= '0;
            r2_r   <= '0;
            pred_r <= '0;
            deg_r  <= 1'b0;
            case (s_tuser)
              REQ_FIT:     state <= !fit_full ? ST_F_XX : (s_tlast ? ST_FD_SX : ST_IDLE);
              REQ_SCORE:   state <= !score_full ? ST_S_P : (s_tlast ? ST_SD_SY : ST_IDLE);
              REQ_PREDICT: state <= ST_S_P;
              default:     state <= ST_IDLE;
            endcase
          end
        end

        // Fit sample accumulation
        ST_F_XX: begin
          fit_count <= fit_count + COUNT_W'(1);
          fit_sum_x <= sat48(WIDE_W'(fit_sum_x) + WIDE_W'(x_r));
          fit_sum_y <= sat48(WIDE_W'(fit_sum_y) + WIDE_W'(y_r));
          state     <= ST_F_YY;
        end
        ST_F_YY: begin
          fit_sum_xx <= sat64(WIDE_W'(fit_sum_xx) + prod_fl);
          state      <= ST_F_XY;
        end
        ST_F_XY: begin
          fit_sum_yy <= sat64(WIDE_W'(fit_sum_yy) + prod_fl);
          state      <= ST_F_XYA;
        end
        ST_F_XYA: begin
          fit_sum_xy <= sat64(WIDE_W'(fit_sum_xy) + prod_fl);
          state      <= last_r ? ST_FD_SX : ST_IDLE;
        end

        // Fit close: means, variances, covariance and slope
        ST_FD_SX: if (div_done) begin
          mx <= sat32(q_w); issued <= 1'b0; state <= ST_FD_SY;
        end
        ST_FD_SY: if (div_done) begin
          my <= sat32(q_w); issued <= 1'b0; state <= ST_FD_SXX;
        end
        ST_FD_SXX: if (div_done) begin
          issued <= 1'b0; state <= ST_FM_VX;
        end
        ST_FM_VX: state <= ST_FA_VX;
        ST_FA_VX: begin
          vx <= var_v; state <= ST_FD_SYY;
        end
        ST_FD_SYY: if (div_done) begin
          issued <= 1'b0; state <= ST_FM_VY;
        end
        ST_FM_VY: state <= ST_FA_VY;
        ST_FA_VY: begin
          vy <= var_v; state <= ST_FD_SXY;
        end
        ST_FD_SXY: if (div_done) begin
          issued <= 1'b0; state <= ST_FM_COV;
        end
        ST_FM_COV: state <= ST_FA_COV;
        ST_FA_COV: begin
          cov <= sat64(q_w - prod_fl);
          if (vx == '0) begin
            slope_r <= '0;
            state   <= ST_FM_ICPT;
          end else begin
            state <= ST_FD_SLOPE;
          end
        end
        ST_FD_SLOPE: if (div_done) begin
          slope_r <= sat32(q_w); issued <= 1'b0; state <= ST_FM_ICPT;
        end

        // Model update and correlation
        ST_FM_ICPT: state <= ST_FA_ICPT;
        ST_FA_ICPT: begin
          model_slope     <= slope_r;
          model_intercept <= sat32(WIDE_W'(my) - prod_fl);
          if (vx == '0 || vy == '0) begin
            deg_r <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_FQ_X;
          end
        end
        ST_FQ_X: if (sq_done) begin
          sx <= sq_root; issued <= 1'b0; state <= ST_FQ_Y;
        end
        ST_FQ_Y: if (sq_done) begin
          issued <= 1'b0; state <= ST_FM_DEN;
        end
        ST_FM_DEN: state <= ST_FD_CORR;
        ST_FD_CORR: if (div_done) begin
          corr_r <= corr_v; issued <= 1'b0; state <= ST_DONE;
        end

        // Prediction, shared by score samples
        ST_S_P: state <= ST_S_PA;
        ST_S_PA: begin
          if (kind_r == REQ_PREDICT) begin
            pred_r <= pred_v;
            state  <= ST_DONE;
          end else begin
            e_r   <= e_diff[32] ? e_neg[31:0] : e_diff[31:0];
            state <= ST_S_EE;
          end
        end
        ST_S_EE: begin
          score_sum_yy <= sat64(WIDE_W'(score_sum_yy) + prod_fl);
          state        <= ST_S_EEA;
        end
        ST_S_EEA: begin
          residual_sq_sum <= sat64(WIDE_W'(residual_sq_sum) + prod_fl);
          score_count     <= score_count + COUNT_W'(1);
          score_sum_y     <= sat48(WIDE_W'(score_sum_y) + WIDE_W'(y_r));
          state           <= last_r ? ST_SD_SY : ST_IDLE;
        end

        // Score close: SST, SSR and R squared
        ST_SD_SY: if (div_done) begin
          my <= sat32(q_w); issued <= 1'b0; state <= ST_SD_SYY;
        end
        ST_SD_SYY: if (div_done) begin
          issued <= 1'b0; state <= ST_SM_SST;
        end
        ST_SM_SST: state <= ST_SA_SST;
        ST_SA_SST: begin
          vx <= var_v; state <= ST_SD_SSR;
        end
        ST_SD_SSR: if (div_done) begin
          cov    <= div_quot;
          issued <= 1'b0;
          if (vx == '0) begin
            deg_r <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_SD_R2;
          end
        end
        ST_SD_R2: if (div_done) begin
          r2_r <= sat32(ONE_FX - q_w); issued <= 1'b0; state <= ST_DONE;
        end

        // Hand the result to the output register, close the set
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {pred_r, r2_r, corr_r, model_intercept, model_slope};
            m_tuser  <= {deg_r, kind_r};
            if (kind_r == REQ_FIT) begin
              fit_count  <= '0;
              fit_sum_x  <= '0;
              fit_sum_y  <= '0;
              fit_sum_xx <= '0;
              fit_sum_yy <= '0;
              fit_sum_xy <= '0;
            end
            if (kind_r == REQ_SCORE) begin
              score_count     <= '0;
              score_sum_y     <= '0;
              score_sum_yy    <= '0;
              residual_sq_sum <= '0;
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `LRFS_NEXT(ap_unknown_dropped, s_tvalid && s_tready && s_tuser == REQ_NONE, state == ST_IDLE, "unknown request started work")
  `LRFS_IMPLIES(ap_degenerate_zero, m_tvalid && m_tuser[2], m_tdata[95:64] == '0 && m_tdata[127:96] == '0, "degenerate result carries r or R squared")
  `LRFS_IMPLIES(ap_corr_range, m_tvalid, $signed(m_tdata[95:64]) <= CORR_MAX32 && $signed(m_tdata[95:64]) >= -CORR_MAX32, "correlation out of range")
  `LRFS_IMPLIES(ap_pred_only, m_tvalid && m_tuser[1:0] != REQ_PREDICT, m_tdata[159:128] == '0, "prediction field set on fit or score result")

endmodule
